// ===== rtl/core/tgarle_pkg.sv =====
// Package for the TGA run-length pixel decoder.
// Holds configuration indexes, pixel format codes, shared structs and helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tgarle_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_RLE_ENABLE   = 2'd0;
    localparam logic [1:0] CFG_PIXEL_FORMAT = 2'd1;
    localparam logic [1:0] CFG_PIXEL_COUNT  = 2'd2;

    // Pixel format codes (code 3 behaves as 32-bit)
    localparam logic [1:0] FMT_16_5551 = 2'd0;
    localparam logic [1:0] FMT_24_BGR  = 2'd1;
    localparam logic [1:0] FMT_32_BGRA = 2'd2;

    localparam logic [1:0]  RESET_PIXEL_FORMAT = FMT_32_BGRA;
    localparam logic [31:0] RESET_PIXEL_COUNT  = 32'd1;

    typedef struct packed {
        logic        rle_enable;
        logic [1:0]  pixel_format;
        logic [31:0] pixel_count;
    } tgarle_cfg_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [7:0] repeat_count;
        logic       overrun;
        logic       image_done;
    } tgarle_result_t;

    // Bytes per pixel for a format code
    function automatic logic [2:0] bytes_per_pixel(input logic [1:0] fmt);
        logic [2:0] bpp;
        case (fmt)
            FMT_16_5551: bpp = 3'd2;
            FMT_24_BGR:  bpp = 3'd3;
            default:     bpp = 3'd4;
        endcase
        return bpp;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/tgarle_decode.sv =====
// Decoder core: packet phase, pixel byte gathering, colour conversion and counting.
// Depends on tgarle_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tgarle_decode (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     step_en,
    input  wire  [7:0]              data_byte,
    input  wire                     start_of_image,
    input  wire tgarle_pkg::tgarle_cfg_t cfg,
    output logic                    res_valid,
    output tgarle_pkg::tgarle_result_t res
);
    import tgarle_pkg::*;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_RUN    = 2'd1,
        PH_RAW    = 2'd2,
        PH_DONE   = 2'd3
    } phase_t;

    phase_t      phase_reg,    phase_next;
    logic [1:0]  bpos_reg,     bpos_next;
    logic [23:0] gath_reg,     gath_next;
    logic [7:0]  pleft_reg,    pleft_next;
    logic [31:0] pdone_reg,    pdone_next;

    // State as seen by this byte (start of image clears it first)
    phase_t      cur_phase;
    logic [1:0]  cur_bpos;
    logic [23:0] cur_gath;
    logic [7:0]  cur_pleft;
    logic [31:0] cur_pdone;

    logic [32:0] remain_wide;
    logic [31:0] remain;
    logic        ignore;
    logic        complete;
    logic        emit;
    logic [7:0]  want;
    logic        over;
    logic [7:0]  rep;
    logic        finished;
    logic [7:0]  b0, b1, b2;

    assign cur_phase = start_of_image ? PH_HEADER : phase_reg;
    assign cur_bpos  = start_of_image ? 2'd0  : bpos_reg;
    assign cur_gath  = start_of_image ? 24'd0 : gath_reg;
    assign cur_pleft = start_of_image ? 8'd0  : pleft_reg;
    assign cur_pdone = start_of_image ? 32'd0 : pdone_reg;

    // Pixels left in the image; borrow means more done than asked for
    assign remain_wide = {1'b0, cfg.pixel_count} - {1'b0, cur_pdone};
    assign remain      = remain_wide[31:0];
    assign ignore      = (cur_phase == PH_DONE) || remain_wide[32] || (remain == 32'd0);

    assign complete = ({1'b0, cur_bpos} + 3'd1) >= bytes_per_pixel(cfg.pixel_format);

    assign b0 = cur_gath[7:0];
    assign b1 = cur_gath[15:8];
    assign b2 = cur_gath[23:16];

    // A run pixel asks for the whole packet, any other pixel for one
    assign want = (cfg.rle_enable && cur_phase == PH_RUN) ? cur_pleft : 8'd1;

    // Clamp the wanted count to the pixels left; done when it takes them all
    assign over     = (remain[31:8] == 24'd0) && (remain[7:0] < want);
    assign rep      = over ? remain[7:0] : want;
    assign finished = (remain[31:8] == 24'd0) && (remain[7:0] == rep);

    // Next-state and result selection
    always_comb begin
        phase_next = cur_phase;
        bpos_next  = cur_bpos;
        gath_next  = cur_gath;
        pleft_next = cur_pleft;
        pdone_next = cur_pdone;
        emit       = 1'b0;

        if (!ignore) begin
            if (cfg.rle_enable && cur_phase == PH_HEADER) begin
                pleft_next = {1'b0, data_byte[6:0]} + 8'd1;
                phase_next = data_byte[7] ? PH_RUN : PH_RAW;
                bpos_next  = 2'd0;
                gath_next  = 24'd0;
            end else if (!complete) begin
                case (cur_bpos)
                    2'd0:    gath_next[7:0]   = cur_gath[7:0]   | data_byte;
                    2'd1:    gath_next[15:8]  = cur_gath[15:8]  | data_byte;
                    2'd2:    gath_next[23:16] = cur_gath[23:16] | data_byte;
                    default: gath_next        = cur_gath;
                endcase
                bpos_next = cur_bpos + 2'd1;
            end else begin
                emit      = 1'b1;
                bpos_next = 2'd0;
                gath_next = 24'd0;
                if (cfg.rle_enable) begin
                    if (cur_phase == PH_RUN) begin
                        pleft_next = 8'd0;
                        phase_next = PH_HEADER;
                    end else begin
                        pleft_next = cur_pleft - 8'd1;
                        if (pleft_next == 8'd0) begin
                            phase_next = PH_HEADER;
                        end
                    end
                end
                pdone_next = cur_pdone + {24'd0, rep};
                if (finished) begin
                    phase_next = PH_DONE;
                end
            end
        end
    end

    // Colour conversion of the completed pixel
    always_comb begin
        res = '0;
        case (cfg.pixel_format)
            FMT_16_5551: begin
                res.red   = {data_byte[6:2], 3'b000};
                res.green = {data_byte[1:0], b0[7:5], 3'b000};
                res.blue  = {b0[4:0], 3'b000};
                res.alpha = data_byte[7] ? 8'd0 : 8'd255;
            end
            FMT_24_BGR: begin
                res.red   = data_byte;
                res.green = b1;
                res.blue  = b0;
                res.alpha = 8'd255;
            end
            default: begin
                res.red   = b2;
                res.green = b1;
                res.blue  = b0;
                res.alpha = data_byte;
            end
        endcase
        res.repeat_count = rep;
        res.overrun      = over;
        res.image_done   = finished;
    end

    assign res_valid = emit;

    // Decoder state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HEADER;
            bpos_reg  <= 2'd0;
            gath_reg  <= 24'd0;
            pleft_reg <= 8'd0;
            pdone_reg <= 32'd0;
        end else if (step_en) begin
            phase_reg <= phase_next;
            bpos_reg  <= bpos_next;
            gath_reg  <= gath_next;
            pleft_reg <= pleft_next;
            pdone_reg <= pdone_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/tgarle_out_reg.sv =====
// Result register of the decoder, drives the m_ channel.
// Depends on tgarle_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tgarle_out_reg (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire                        load,
    input  wire tgarle_pkg::tgarle_result_t res,
    input  wire                        m_ready,
    output logic                       m_valid,
    output tgarle_pkg::tgarle_result_t m_res
);
    import tgarle_pkg::*;

    logic           valid_reg, valid_next;
    tgarle_result_t res_reg;

    // Valid holds until the transaction completes or a new result lands
    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload, no reset needed
    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

    assign m_valid = valid_reg;
    assign m_res   = res_reg;

endmodule

`default_nettype wire

// ===== rtl/core/tga_rle_pixel_decoder_unit.sv =====
// Top level of the TGA run-length pixel decoder: configuration registers,
// input register, decoder core and result register.
// Depends on tgarle_pkg, tgarle_decode, tgarle_out_reg.
//
//   Channel  Dir  Handshake         Payload
//   s_       in   s_valid/s_ready   data_byte, start_of_image
//   m_       out  m_valid/m_ready   red, green, blue, alpha, repeat_count,
//                                   overrun, image_done
//   cfg_     in   cfg_we            cfg_addr, cfg_wdata
//
// One byte per cycle sustained while the result register is not held. A byte waits
// in the input register, and its pixel, if any, loads into the result register as it leaves.
// Bytes that finish no pixel give no transaction. When the result register is
// held by m_ready low, the input register stalls and s_ready drops.
// Synchronous active-low reset; configuration returns to its defaults.
`timescale 1ns / 1ps
`default_nettype none

module tga_rle_pixel_decoder_unit (
    input  wire         aclk,
    input  wire         aresetn,
    // Configuration
    input  wire         cfg_we,
    input  wire  [1:0]  cfg_addr,
    input  wire  [31:0] cfg_wdata,
    // Byte input
    input  wire         s_valid,
    output logic        s_ready,
    input  wire  [7:0]  s_data_byte,
    input  wire         s_start_of_image,
    // Pixel output
    output logic        m_valid,
    input  wire         m_ready,
    output logic [7:0]  m_red,
    output logic [7:0]  m_green,
    output logic [7:0]  m_blue,
    output logic [7:0]  m_alpha,
    output logic [7:0]  m_repeat_count,
    output logic        m_overrun,
    output logic        m_image_done
);
    import tgarle_pkg::*;

    tgarle_cfg_t    cfg_reg;
    logic           in_valid_reg;
    logic [7:0]     in_byte_reg;
    logic           in_sof_reg;
    logic           advance;
    logic           res_valid;
    tgarle_result_t res;
    tgarle_result_t m_res;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rle_enable   <= 1'b0;
            cfg_reg.pixel_format <= RESET_PIXEL_FORMAT;
            cfg_reg.pixel_count  <= RESET_PIXEL_COUNT;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_RLE_ENABLE:   cfg_reg.rle_enable   <= cfg_wdata[0];
                CFG_PIXEL_FORMAT: cfg_reg.pixel_format <= cfg_wdata[1:0];
                CFG_PIXEL_COUNT:  cfg_reg.pixel_count  <= cfg_wdata;
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    // Input stage moves on when the result register has room
    assign advance = in_valid_reg && (!m_valid || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_data_byte;
            in_sof_reg  <= s_start_of_image;
        end
    end

    tgarle_decode u_decode (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step_en        (advance),
        .data_byte      (in_byte_reg),
        .start_of_image (in_sof_reg),
        .cfg            (cfg_reg),
        .res_valid      (res_valid),
        .res            (res)
    );

    tgarle_out_reg u_out_reg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (advance && res_valid),
        .res     (res),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_res   (m_res)
    );

    assign m_red          = m_res.red;
    assign m_green        = m_res.green;
    assign m_blue         = m_res.blue;
    assign m_alpha        = m_res.alpha;
    assign m_repeat_count = m_res.repeat_count;
    assign m_overrun      = m_res.overrun;
    assign m_image_done   = m_res.image_done;

endmodule

`default_nettype wire

// ===== dv/tb_tga_rle_pixel_decoder_unit.sv =====
// Testbench for tga_rle_pixel_decoder_unit: drives TGA pixel-data bytes and
// checks every decoded pixel against a predictor with its own decode state.
// Depends on tgarle_pkg and the RTL of the decoder unit.
`timescale 1ns / 1ps

module tb_tga_rle_pixel_decoder_unit;

    import tgarle_pkg::*;

    localparam int          ITEM_TARGET  = 2000;
    localparam int          STALL_LIMIT  = 2000;
    localparam int          DRAIN_CYCLES = 8;
    localparam logic [1:0]  CFG_UNUSED   = 2'd3;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_RUN,
        PH_RAW,
        PH_DONE
    } decode_phase_t;

    // Predicts decoded pixels from accepted bytes and checks them on arrival
    class tga_pixel_predictor;
        bit            rle_enable;
        bit [1:0]      pixel_format;
        bit [31:0]     pixel_count;
        decode_phase_t phase;
        bit [1:0]      byte_pos;
        bit [23:0]     gathered;
        bit [7:0]      packet_left;
        bit [31:0]     pixels_done;
        tgarle_result_t expected_pixels[$];
        int            errors;
        int            decoded_bytes;

        function new();
            rle_enable   = 1'b0;
            pixel_format = RESET_PIXEL_FORMAT;
            pixel_count  = RESET_PIXEL_COUNT;
            errors       = 0;
            decoded_bytes = 0;
            restart();
        endfunction

        function void restart();
            phase       = PH_HEADER;
            byte_pos    = '0;
            gathered    = '0;
            packet_left = '0;
            pixels_done = '0;
        endfunction

        function void write_reg(bit [1:0] idx, bit [31:0] value);
            case (idx)
                CFG_RLE_ENABLE:   rle_enable   = value[0];
                CFG_PIXEL_FORMAT: pixel_format = value[1:0];
                CFG_PIXEL_COUNT:  pixel_count  = value;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction

        // Adds a byte to the pixel under assembly; 1 when the pixel is complete
        function bit gather(bit [7:0] b);
            int unsigned bpp;
            case (pixel_format)
                FMT_16_5551: bpp = 2;
                FMT_24_BGR:  bpp = 3;
                default:     bpp = 4;
            endcase
            if (int'(byte_pos) + 1 >= bpp) begin
                byte_pos = '0;
                return 1'b1;
            end
            gathered = gathered | (24'(b) << (8 * byte_pos));
            byte_pos = byte_pos + 2'd1;
            return 1'b0;
        endfunction

        // Converts the finished pixel and queues it with its clamped count
        function void queue_pixel(bit [7:0] last, int unsigned want);
            tgarle_result_t px;
            bit [31:0]      remaining;
            bit [31:0]      rep;
            bit [7:0]       b0;
            bit [7:0]       b1;
            bit [7:0]       b2;
            remaining = pixel_count - pixels_done;
            rep       = want;
            px.overrun = 1'b0;
            if (rep > remaining) begin
                rep        = remaining;
                px.overrun = 1'b1;
            end
            b0 = gathered[7:0];
            b1 = gathered[15:8];
            b2 = gathered[23:16];
            case (pixel_format)
                FMT_16_5551: begin
                    px.red   = {last[6:2], 3'b000};
                    px.green = {last[1:0], b0[7:5], 3'b000};
                    px.blue  = {b0[4:0], 3'b000};
                    px.alpha = last[7] ? 8'd0 : 8'd255;
                end
                FMT_24_BGR: begin
                    px.red   = last;
                    px.green = b1;
                    px.blue  = b0;
                    px.alpha = 8'd255;
                end
                default: begin
                    px.red   = b2;
                    px.green = b1;
                    px.blue  = b0;
                    px.alpha = last;
                end
            endcase
            gathered        = '0;
            pixels_done     = pixels_done + rep;
            px.repeat_count = rep[7:0];
            px.image_done   = (pixels_done == pixel_count);
            if (px.image_done)
                phase = PH_DONE;
            expected_pixels.push_back(px);
        endfunction

        // Accepted input transaction
        function void note_byte(bit [7:0] b, bit sof);
            int unsigned want;
            if (sof)
                restart();
            if (phase == PH_DONE || pixels_done >= pixel_count)
                return;
            decoded_bytes++;
            if (!rle_enable) begin
                if (gather(b))
                    queue_pixel(b, 1);
                return;
            end
            if (phase == PH_HEADER) begin
                packet_left = {1'b0, b[6:0]} + 8'd1;
                phase       = b[7] ? PH_RUN : PH_RAW;
                byte_pos    = '0;
                gathered    = '0;
                return;
            end
            if (!gather(b))
                return;
            if (phase == PH_RUN) begin
                want        = packet_left;
                packet_left = '0;
                phase       = PH_HEADER;
                queue_pixel(b, want);
            end else begin
                packet_left = packet_left - 8'd1;
                if (packet_left == 0)
                    phase = PH_HEADER;
                queue_pixel(b, 1);
            end
        endfunction

        function void report(string field, int unsigned want, int unsigned got);
            errors++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
        endfunction

        // Result transaction against the oldest expected pixel
        function void check_pixel(tgarle_result_t got);
            tgarle_result_t want;
            if (expected_pixels.size() == 0) begin
                errors++;
                $display("%0t: unexpected pixel, expected none, got %h", $time, got);
                return;
            end
            want = expected_pixels.pop_front();
            if (got.red != want.red)
                report("red", want.red, got.red);
            if (got.green != want.green)
                report("green", want.green, got.green);
            if (got.blue != want.blue)
                report("blue", want.blue, got.blue);
            if (got.alpha != want.alpha)
                report("alpha", want.alpha, got.alpha);
            if (got.repeat_count != want.repeat_count)
                report("repeat_count", want.repeat_count, got.repeat_count);
            if (got.overrun != want.overrun)
                report("overrun", want.overrun, got.overrun);
            if (got.image_done != want.image_done)
                report("image_done", want.image_done, got.image_done);
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [1:0]  cfg_addr;
    logic [31:0] cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_data_byte;
    logic        s_start_of_image;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_red;
    logic [7:0]  m_green;
    logic [7:0]  m_blue;
    logic [7:0]  m_alpha;
    logic [7:0]  m_repeat_count;
    logic        m_overrun;
    logic        m_image_done;

    tga_pixel_predictor pixels = new();
    bit                 quiet = 1'b0;
    bit                 sof_pending;
    int                 hold_cycles = 0;
    int                 idle_cycles = 0;

    tga_rle_pixel_decoder_unit i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_addr         (cfg_addr),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .s_start_of_image (s_start_of_image),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_red            (m_red),
        .m_green          (m_green),
        .m_blue           (m_blue),
        .m_alpha          (m_alpha),
        .m_repeat_count   (m_repeat_count),
        .m_overrun        (m_overrun),
        .m_image_done     (m_image_done)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    // Mostly short stalls, now and then a long one
    function automatic int stall_length();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(4, 30);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 15))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Result side back-pressure
    always @(posedge aclk) begin
        if (hold_cycles != 0) begin
            m_ready     <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else if (!quiet && $urandom_range(0, 3) == 0) begin
            m_ready     <= 1'b0;
            hold_cycles <= stall_length() - 1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Result checking
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            pixels.check_pixel({m_red, m_green, m_blue, m_alpha, m_repeat_count,
                                m_overrun, m_image_done});
    end

    // Watchdog on cycles with no transaction at all
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("** tga_rle_pixel_decoder_unit: FAILED **");
            $finish;
        end
    end

    // One input transaction; start of image comes from sof_pending
    task automatic send_byte(logic [7:0] b);
        int gap;
        gap = (!quiet && $urandom_range(0, 2) == 0) ? stall_length() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_data_byte      <= b;
        s_start_of_image <= sof_pending;
        do @(posedge aclk); while (!s_ready);
        pixels.note_byte(b, sof_pending);
        sof_pending = 1'b0;
    endtask

    task automatic send_pixel(int bpp);
        repeat (bpp) send_byte(pick_byte());
    endtask

    // Stop input and let every pending pixel and in-flight byte drain
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pixels.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Writes all three registers, upper data bits random where unused
    task automatic write_regs(bit rle, bit [1:0] fmt, bit [31:0] count, bit touch_unused);
        logic [31:0] data;
        data = ($urandom() & ~32'h1) | rle;
        cfg_we <= 1'b1; cfg_addr <= CFG_RLE_ENABLE; cfg_wdata <= data;
        pixels.write_reg(CFG_RLE_ENABLE, data);
        @(posedge aclk);
        data = ($urandom() & ~32'h3) | fmt;
        cfg_addr <= CFG_PIXEL_FORMAT; cfg_wdata <= data;
        pixels.write_reg(CFG_PIXEL_FORMAT, data);
        @(posedge aclk);
        cfg_addr <= CFG_PIXEL_COUNT; cfg_wdata <= count;
        pixels.write_reg(CFG_PIXEL_COUNT, count);
        @(posedge aclk);
        if (touch_unused) begin
            data = $urandom();
            cfg_addr <= CFG_UNUSED; cfg_wdata <= data;
            pixels.write_reg(CFG_UNUSED, data);
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
    endtask

    // One image: new settings, then mostly well-formed packets with noise
    task automatic random_image();
        bit          rle;
        bit [1:0]    fmt;
        bit [31:0]   count;
        int          bpp;
        int          r;
        int          target;
        int          px;
        int          n;
        bit          is_run;
        bit          resume;
        wait_idle();
        rle = $urandom_range(0, 1);
        fmt = $urandom_range(0, 3);
        r   = $urandom_range(0, 99);
        if (r < 4)
            count = 32'd0;
        else if (r < 8)
            count = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd4294836225;
        else if (r < 20)
            count = $urandom_range(1, 4);
        else if (r < 90)
            count = $urandom_range(5, 60);
        else
            count = $urandom_range(61, 400);
        write_regs(rle, fmt, count, $urandom_range(0, 9) == 0);
        bpp    = (fmt == FMT_16_5551) ? 2 : (fmt == FMT_24_BGR) ? 3 : 4;
        target = (count == 0 || count > 400) ? $urandom_range(1, 60) : int'(count);
        quiet  = ($urandom_range(0, 4) == 0);
        // Now and then carry on with the held decode state under new settings
        resume      = ($urandom_range(0, 7) == 0);
        sof_pending = !resume;
        px = 0;
        while (px < target) begin
            if (rle) begin
                n      = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 128)
                                                     : $urandom_range(1, 8);
                is_run = $urandom_range(0, 1);
                send_byte({is_run, 7'(n - 1)});
                if (is_run)
                    send_pixel(bpp);
                else
                    repeat (n) send_pixel(bpp);
                px += n;
            end else begin
                send_pixel(bpp);
                px++;
            end
            if ($urandom_range(0, 49) == 0)
                send_byte(pick_byte());
            if ($urandom_range(0, 199) == 0)
                sof_pending = 1'b1;
        end
        // Trailing bytes past the image end
        repeat ($urandom_range(0, 3)) send_byte(pick_byte());
    endtask

    initial begin
        aresetn          <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_addr         <= CFG_RLE_ENABLE;
        cfg_wdata        <= '0;
        s_valid          <= 1'b0;
        s_data_byte      <= '0;
        s_start_of_image <= 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: uncompressed 32-bit, one pixel, then an ignored byte
        sof_pending = 1'b1;
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h80);
        send_byte(8'h7F);
        send_byte(8'hA5);
        wait_idle();

        // 5551 run of two with alpha clear, then raw packet past the image end
        write_regs(1'b1, FMT_16_5551, 32'd3, 1'b1);
        sof_pending = 1'b1;
        send_byte(8'h81);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'h01);
        send_byte(8'h00);
        send_byte(8'h7F);
        send_byte(8'h1F);
        send_byte(8'h00);
        wait_idle();

        // Longest run clamped to the five pixels of the image
        write_regs(1'b1, FMT_24_BGR, 32'd5, 1'b0);
        sof_pending = 1'b1;
        send_byte(8'hFF);
        send_byte(8'h12);
        send_byte(8'h34);
        send_byte(8'h56);
        wait_idle();

        // Format code 3, then switch to 16-bit with three bytes already held
        write_regs(1'b0, 2'd3, 32'd2, 1'b0);
        sof_pending = 1'b1;
        send_byte(8'h11);
        send_byte(8'h22);
        send_byte(8'h33);
        wait_idle();
        write_regs(1'b0, FMT_16_5551, 32'd2, 1'b0);
        send_byte(8'hC3);
        send_byte(8'h01);
        send_byte(8'hFE);

        while (pixels.decoded_bytes < ITEM_TARGET)
            random_image();

        quiet = 1'b0;
        wait_idle();
        if (pixels.errors == 0 && pixels.pending() == 0)
            $display("** tga_rle_pixel_decoder_unit: PASSED **");
        else
            $display("** tga_rle_pixel_decoder_unit: FAILED **");
        $finish;
    end

endmodule
